// ===== rtl/ttua_pkg.sv =====
// ----------------------------------------------------------------------------
// ttua_pkg
// Shared types and constants for the trigger time unwrap and align block.
// ----------------------------------------------------------------------------
`default_nettype none

package ttua_pkg;

    // Field widths.
    localparam int COUNT_W     = 31;
    localparam int STAMP_W     = 32;
    localparam int SPILL_W     = 16;
    localparam int PERIOD_W    = 32;
    localparam int TICKS_W     = 48;
    localparam int ALIGN_W     = 48;
    localparam int FULL_W      = 64;
    localparam int CFG_INDEX_W = 8;

    // The item carries a fixed set of four digitizer slots.
    localparam int NUM_DIG_MAX = 4;
    localparam int DIG_IDX_W   = 2;

    // Configuration registers, one period per digitizer slot.
    localparam int NUM_CFG_REGS = NUM_DIG_MAX;
    localparam int CFG_SEL_W    = 2;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'h0800_0000;

    // Defaults of the top level parameters.
    localparam int DEF_NUM_DIGITIZERS = 4;
    localparam int DEF_MAX_WRAP_STEPS = 16;

    // Unwrap arithmetic.
    localparam logic [FULL_W-1:0] WRAP_STEP = 64'h0000_0000_8000_0000;
    localparam logic signed [27:0] TICKS_PER_SEC = 28'sd125000000;
    localparam logic signed [FULL_W-1:0] TOL_POS = 64'sd250000000;
    localparam logic signed [FULL_W-1:0] TOL_NEG = -64'sd250000000;

    typedef logic [NUM_DIG_MAX-1:0][PERIOD_W-1:0] period_arr_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MULK,
        ST_ERR,
        ST_SEARCH,
        ST_FULL,
        ST_DIFF,
        ST_SCALE,
        ST_ACCUM,
        ST_ALIGN
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic load;
        logic mulk;
        logic err;
        logic step;
        logic fail;
        logic full;
        logic diff;
        logic scale;
        logic accum;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic accepted;
        logic mismatch;
        logic out_busy;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/ttua_intf.sv =====
// ----------------------------------------------------------------------------
// ttua interfaces
// Valid/ready channels for trigger items, result items and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface ttua_trig_if
    import ttua_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 first_event;
    logic [SPILL_W-1:0]   spill_id;
    logic [COUNT_W-1:0]   count_dig0;
    logic [COUNT_W-1:0]   count_dig1;
    logic [COUNT_W-1:0]   count_dig2;
    logic [COUNT_W-1:0]   count_dig3;
    logic [STAMP_W-1:0]   stamp_dig0;
    logic [STAMP_W-1:0]   stamp_dig1;
    logic [STAMP_W-1:0]   stamp_dig2;
    logic [STAMP_W-1:0]   stamp_dig3;

    modport source (
        output valid, first_event, spill_id,
        output count_dig0, count_dig1, count_dig2, count_dig3,
        output stamp_dig0, stamp_dig1, stamp_dig2, stamp_dig3,
        input  ready
    );

    modport sink (
        input  valid, first_event, spill_id,
        input  count_dig0, count_dig1, count_dig2, count_dig3,
        input  stamp_dig0, stamp_dig1, stamp_dig2, stamp_dig3,
        output ready
    );
endinterface

interface ttua_result_if
    import ttua_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [TICKS_W-1:0]         spill_ticks_dig0;
    logic [TICKS_W-1:0]         spill_ticks_dig1;
    logic [TICKS_W-1:0]         spill_ticks_dig2;
    logic [TICKS_W-1:0]         spill_ticks_dig3;
    logic signed [ALIGN_W-1:0]  align_dig0;
    logic signed [ALIGN_W-1:0]  align_dig2;
    logic signed [ALIGN_W-1:0]  align_dig3;
    logic [NUM_DIG_MAX-1:0]     unwrap_failed;

    modport source (
        output valid,
        output spill_ticks_dig0, spill_ticks_dig1, spill_ticks_dig2, spill_ticks_dig3,
        output align_dig0, align_dig2, align_dig3, unwrap_failed,
        input  ready
    );

    modport sink (
        input  valid,
        input  spill_ticks_dig0, spill_ticks_dig1, spill_ticks_dig2, spill_ticks_dig3,
        input  align_dig0, align_dig2, align_dig3, unwrap_failed,
        output ready
    );
endinterface

interface ttua_cfg_if
    import ttua_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [PERIOD_W-1:0]    data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/ttua_period_regs.sv =====
// ----------------------------------------------------------------------------
// ttua_period_regs
// Per-digitizer clock period registers written through the config channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ttua_period_regs
    import ttua_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    ttua_cfg_if.sink   cfg,
    output period_arr_t period
);

    period_arr_t period_reg;

    assign cfg.ready = 1'b1;
    assign period    = period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_DIG_MAX; i++)
            begin
                period_reg[i] <= PERIOD_RESET;
            end
        end
        else if (cfg.valid && cfg.ready && (cfg.index < CFG_INDEX_W'(NUM_CFG_REGS)))
        begin
            // Writes to indexes beyond the register list are dropped.
            period_reg[cfg.index[CFG_SEL_W-1:0]] <= cfg.data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ttua_ctrl.sv =====
// ----------------------------------------------------------------------------
// ttua_ctrl
// Sequencer that walks each digitizer through unwrap, spill and scaling steps.
// ----------------------------------------------------------------------------
`default_nettype none

module ttua_ctrl
    import ttua_pkg::*;
#(
    parameter int NUM_DIGITIZERS = DEF_NUM_DIGITIZERS,
    parameter int MAX_WRAP_STEPS = DEF_MAX_WRAP_STEPS,
    localparam int DIG_W  = $clog2(NUM_DIGITIZERS),
    localparam int STEP_W = $clog2(MAX_WRAP_STEPS + 1)
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire status_t     status,
    output cmd_t             cmd,
    output logic [DIG_W-1:0] dig
);

    state_t            state_reg;
    state_t            state_next;
    logic [DIG_W-1:0]  dig_reg;
    logic [STEP_W-1:0] step_reg;
    logic              last_dig;
    logic              step_limit;

    assign dig        = dig_reg;
    assign last_dig   = (dig_reg == DIG_W'(NUM_DIGITIZERS - 1));
    assign step_limit = (step_reg == STEP_W'(MAX_WRAP_STEPS));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (status.accepted) state_next = ST_LOAD;
            ST_LOAD:   state_next = ST_MULK;
            ST_MULK:   state_next = ST_ERR;
            ST_ERR:    state_next = ST_SEARCH;
            ST_SEARCH:
            begin
                if (!status.mismatch || step_limit)
                begin
                    state_next = ST_FULL;
                end
            end
            ST_FULL:   state_next = ST_DIFF;
            ST_DIFF:   state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_ACCUM;
            ST_ACCUM:  state_next = last_dig ? ST_ALIGN : ST_LOAD;
            ST_ALIGN:  if (!status.out_busy) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:   cmd.in_ready = 1'b1;
            ST_LOAD:   cmd.load     = 1'b1;
            ST_MULK:   cmd.mulk     = 1'b1;
            ST_ERR:    cmd.err      = 1'b1;
            ST_SEARCH:
            begin
                // Out of steps with the counts still disagreeing flags the digitizer.
                cmd.step = status.mismatch && !step_limit;
                cmd.fail = status.mismatch && step_limit;
            end
            ST_FULL:   cmd.full   = 1'b1;
            ST_DIFF:   cmd.diff   = 1'b1;
            ST_SCALE:  cmd.scale  = 1'b1;
            ST_ACCUM:  cmd.accum  = 1'b1;
            ST_ALIGN:  cmd.finish = !status.out_busy;
            default:   cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            dig_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (status.accepted)
            begin
                dig_reg <= '0;
            end
            else if (state_reg == ST_ACCUM && !last_dig)
            begin
                dig_reg <= dig_reg + DIG_W'(1);
            end
            if (state_reg == ST_LOAD)
            begin
                step_reg <= '0;
            end
            else if (cmd.step)
            begin
                step_reg <= step_reg + STEP_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ttua_datapath.sv =====
// ----------------------------------------------------------------------------
// ttua_datapath
// Tracking state, wrap search arithmetic, tick scaling and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ttua_datapath
    import ttua_pkg::*;
#(
    parameter int NUM_DIGITIZERS = DEF_NUM_DIGITIZERS,
    localparam int DIG_W = $clog2(NUM_DIGITIZERS)
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cmd_t             cmd,
    input  wire logic [DIG_W-1:0] dig,
    input  wire period_arr_t      period,
    output status_t               status,
    ttua_trig_if.sink             trig,
    ttua_result_if.source         result
);

    function automatic logic [ALIGN_W-1:0] align_diff(
        input logic [FULL_W-1:0] a,
        input logic [FULL_W-1:0] b
    );
        logic signed [FULL_W:0] s;
        logic [ALIGN_W-1:0]     r;
        s = $signed({1'b0, a}) - $signed({1'b0, b});
        if (s > $signed(65'sd140737488355327))
        begin
            r = {1'b0, {(ALIGN_W-1){1'b1}}};
        end
        else if (s < $signed(-65'sd140737488355328))
        begin
            r = {1'b1, {(ALIGN_W-1){1'b0}}};
        end
        else
        begin
            r = s[ALIGN_W-1:0];
        end
        return r;
    endfunction

    // Tracking state, one entry per present digitizer.
    logic [FULL_W-1:0]  offset_reg      [NUM_DIGITIZERS];
    logic [FULL_W-1:0]  last_full_reg   [NUM_DIGITIZERS];
    logic [STAMP_W-1:0] last_stamp_reg  [NUM_DIGITIZERS];
    logic [FULL_W-1:0]  spill_start_reg [NUM_DIGITIZERS];
    logic [SPILL_W-1:0] last_spill_reg;

    // Captured item.
    logic                                 first_reg;
    logic                                 new_spill_reg;
    logic [SPILL_W-1:0]                   spill_reg;
    logic [NUM_DIG_MAX-1:0][COUNT_W-1:0]  cnt_reg;
    logic [NUM_DIG_MAX-1:0][STAMP_W-1:0]  stamp_reg;

    // Working registers for the digitizer in progress.
    logic signed [STAMP_W:0]   dts_reg;
    logic signed [60:0]        prod_reg;
    logic [FULL_W-1:0]         dtt_reg;
    logic [FULL_W-1:0]         err_reg;
    logic [FULL_W-1:0]         off_w_reg;
    logic [FULL_W-1:0]         full_reg;
    logic [TICKS_W-1:0]        tick_w_reg;
    logic [55:0]               phi_reg;
    logic [55:0]               plo_reg;

    // Per-item results; slots of absent digitizers stay zero.
    logic [NUM_DIG_MAX-1:0][TICKS_W-1:0] ticks_reg;
    logic [NUM_DIG_MAX-1:0][FULL_W-1:0]  tm_reg;
    logic [NUM_DIG_MAX-1:0]              fail_reg;

    // Result register.
    logic                       out_valid_reg;
    logic [NUM_DIG_MAX-1:0][TICKS_W-1:0] out_ticks_reg;
    logic [ALIGN_W-1:0]         out_align0_reg;
    logic [ALIGN_W-1:0]         out_align2_reg;
    logic [ALIGN_W-1:0]         out_align3_reg;
    logic [NUM_DIG_MAX-1:0]     out_fail_reg;

    logic [DIG_IDX_W-1:0] dig_ext;
    logic [COUNT_W-1:0]   cnt_w;
    logic [STAMP_W-1:0]   st_w;
    logic [FULL_W-1:0]    full_next;
    logic [FULL_W-1:0]    spill_diff;
    logic                 in_range;
    logic signed [FULL_W-1:0] err_s;
    logic                 accepted;

    assign dig_ext   = DIG_IDX_W'(dig);
    assign cnt_w     = cnt_reg[dig_ext];
    assign st_w      = stamp_reg[dig_ext];
    assign full_next = {{(FULL_W-COUNT_W){1'b0}}, cnt_w} + off_w_reg;
    assign spill_diff = full_reg - spill_start_reg[dig];
    assign accepted  = trig.valid && trig.ready;

    // A tick difference of magnitude 2^61 or more is treated as a mismatch
    // outright; inside that range the error term is exact.
    assign in_range = (dtt_reg[63:61] == 3'b000)
                   || ((dtt_reg[63:61] == 3'b111) && (dtt_reg[60:0] != '0));
    assign err_s    = $signed(err_reg);

    assign status.accepted = accepted;
    assign status.mismatch = !in_range || (err_s > TOL_POS) || (err_s < TOL_NEG);
    assign status.out_busy = out_valid_reg && !result.ready;

    assign trig.ready = cmd.in_ready;

    assign result.valid            = out_valid_reg;
    assign result.spill_ticks_dig0 = out_ticks_reg[0];
    assign result.spill_ticks_dig1 = out_ticks_reg[1];
    assign result.spill_ticks_dig2 = out_ticks_reg[2];
    assign result.spill_ticks_dig3 = out_ticks_reg[3];
    assign result.align_dig0       = $signed(out_align0_reg);
    assign result.align_dig2       = $signed(out_align2_reg);
    assign result.align_dig3       = $signed(out_align3_reg);
    assign result.unwrap_failed    = out_fail_reg;

    // Control state and tracking state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            last_spill_reg <= '0;
            for (int i = 0; i < NUM_DIGITIZERS; i++)
            begin
                offset_reg[i]      <= '0;
                last_full_reg[i]   <= '0;
                last_stamp_reg[i]  <= '0;
                spill_start_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.finish)
            begin
                out_valid_reg  <= 1'b1;
                last_spill_reg <= spill_reg;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.load && first_reg)
            begin
                spill_start_reg[dig] <= {{(FULL_W-COUNT_W){1'b0}}, cnt_w};
            end
            if (cmd.full)
            begin
                offset_reg[dig]     <= off_w_reg;
                last_full_reg[dig]  <= full_next;
                last_stamp_reg[dig] <= st_w;
                if (new_spill_reg)
                begin
                    spill_start_reg[dig] <= full_next;
                end
            end
        end
    end

    // Item capture and working arithmetic.
    always_ff @(posedge clk)
    begin
        if (accepted)
        begin
            first_reg     <= trig.first_event;
            spill_reg     <= trig.spill_id;
            new_spill_reg <= !trig.first_event && (trig.spill_id != last_spill_reg);
            cnt_reg[0]    <= trig.count_dig0;
            cnt_reg[1]    <= trig.count_dig1;
            cnt_reg[2]    <= trig.count_dig2;
            cnt_reg[3]    <= trig.count_dig3;
            stamp_reg[0]  <= trig.stamp_dig0;
            stamp_reg[1]  <= trig.stamp_dig1;
            stamp_reg[2]  <= trig.stamp_dig2;
            stamp_reg[3]  <= trig.stamp_dig3;
            ticks_reg     <= '0;
            tm_reg        <= '0;
            fail_reg      <= '0;
        end

        if (cmd.load)
        begin
            // A first event restarts tracking from this item's own count.
            if (first_reg)
            begin
                off_w_reg <= '0;
                dtt_reg   <= '0;
                dts_reg   <= '0;
            end
            else
            begin
                off_w_reg <= offset_reg[dig];
                dtt_reg   <= {{(FULL_W-COUNT_W){1'b0}}, cnt_w} + offset_reg[dig]
                             - last_full_reg[dig];
                dts_reg   <= $signed({1'b0, st_w}) - $signed({1'b0, last_stamp_reg[dig]});
            end
        end

        if (cmd.mulk)
        begin
            prod_reg <= dts_reg * TICKS_PER_SEC;
        end

        if (cmd.err)
        begin
            err_reg <= {{(FULL_W-61){prod_reg[60]}}, prod_reg} - dtt_reg;
        end

        if (cmd.step)
        begin
            off_w_reg <= off_w_reg + WRAP_STEP;
            dtt_reg   <= dtt_reg + WRAP_STEP;
            err_reg   <= err_reg - WRAP_STEP;
        end

        if (cmd.fail)
        begin
            fail_reg[dig_ext] <= 1'b1;
        end

        if (cmd.full)
        begin
            full_reg <= full_next;
        end

        if (cmd.diff)
        begin
            // Negative spill time reads as zero, overlong time saturates.
            if (spill_diff[FULL_W-1])
            begin
                tick_w_reg         <= '0;
                ticks_reg[dig_ext] <= '0;
            end
            else if (spill_diff[FULL_W-2:TICKS_W] != '0)
            begin
                tick_w_reg         <= '1;
                ticks_reg[dig_ext] <= '1;
            end
            else
            begin
                tick_w_reg         <= spill_diff[TICKS_W-1:0];
                ticks_reg[dig_ext] <= spill_diff[TICKS_W-1:0];
            end
        end

        if (cmd.scale)
        begin
            phi_reg <= tick_w_reg[47:24] * period[dig_ext];
            plo_reg <= tick_w_reg[23:0] * period[dig_ext];
        end

        if (cmd.accum)
        begin
            tm_reg[dig_ext] <= {phi_reg, 8'b0} + {24'b0, plo_reg[55:16]};
        end

        if (cmd.finish)
        begin
            out_ticks_reg  <= ticks_reg;
            out_fail_reg   <= fail_reg;
            out_align0_reg <= align_diff(tm_reg[0], tm_reg[1]);
            out_align2_reg <= (NUM_DIGITIZERS > 2) ? align_diff(tm_reg[2], tm_reg[1]) : '0;
            out_align3_reg <= (NUM_DIGITIZERS > 3) ? align_diff(tm_reg[3], tm_reg[1]) : '0;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/trigger_time_unwrap_align.sv =====
// One item is in work at a time: a new item is taken only after the result of
// the last one has been loaded into the result register. The digitizers go
// one after another through a single search and scaling datapath, each
// taking at most MAX_WRAP_STEPS wrap steps. Reset clears all tracking state
// to zero and the periods to 8 ns; the block is ready right after reset.
// ----------------------------------------------------------------------------
// trigger_time_unwrap_align
// Extends wrapping digitizer trigger counts and aligns their spill times.
// ----------------------------------------------------------------------------
`default_nettype none

module trigger_time_unwrap_align
    import ttua_pkg::*;
#(
    parameter int NUM_DIGITIZERS = DEF_NUM_DIGITIZERS,
    parameter int MAX_WRAP_STEPS = DEF_MAX_WRAP_STEPS
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    ttua_trig_if.sink     trig,
    ttua_result_if.source result,
    ttua_cfg_if.sink      cfg
);

    localparam int DIG_W = $clog2(NUM_DIGITIZERS);

    cmd_t             cmd;
    status_t          status;
    logic [DIG_W-1:0] dig;
    period_arr_t      period;

    ttua_period_regs u_period_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .period (period)
    );

    ttua_ctrl #(
        .NUM_DIGITIZERS (NUM_DIGITIZERS),
        .MAX_WRAP_STEPS (MAX_WRAP_STEPS)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd),
        .dig    (dig)
    );

    ttua_datapath #(
        .NUM_DIGITIZERS (NUM_DIGITIZERS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .dig    (dig),
        .period (period),
        .status (status),
        .trig   (trig),
        .result (result)
    );

endmodule

`default_nettype wire

// ===== tb/trigger_time_unwrap_align_test.sv =====
// ----------------------------------------------------------------------------
// trigger_time_unwrap_align_test
// Drives trigger items, period writes and result back-pressure into the
// unwrap and align block. A software copy of the unwrap search, spill
// tracking and period scaling predicts every result item, field by field.
// ----------------------------------------------------------------------------

module trigger_time_unwrap_align_test
    import ttua_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_DIG        = DEF_NUM_DIGITIZERS;
    localparam int MAX_STEPS      = DEF_MAX_WRAP_STEPS;
    localparam int LATENCY        = 8 * NUM_DIG + NUM_DIG * MAX_STEPS + 1;
    localparam int TAIL_CYCLES    = 2 * LATENCY;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int HOLD_CYCLES    = 600;
    localparam int NUM_PHASES     = 7;
    localparam int PHASE_ITEMS    = 170;
    localparam int BACKLOG_PHASE  = 3;
    localparam int DRAIN_PHASE    = 4;
    localparam int DRAIN_ITEM     = 80;
    localparam longint TICK_RATE  = 125_000_000;

    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD_DIG0 = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD_DIG1 = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD_DIG2 = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD_DIG3 = 8'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_SPARE = 8'(NUM_CFG_REGS);

    localparam logic [63:0] TICKS_MAX   = 64'h0000_FFFF_FFFF_FFFF;
    localparam logic [63:0] ALIGN_MAX   = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [63:0] HUGE_LOW    = 64'h2000_0000_0000_0000;
    localparam logic [63:0] HUGE_HIGH   = 64'hE000_0000_0000_0000;
    localparam logic [ALIGN_W-1:0] ALIGN_MIN = 48'h8000_0000_0000;

    typedef struct packed {
        logic                                 first_event;
        logic [SPILL_W-1:0]                   spill_id;
        logic [NUM_DIG_MAX-1:0][COUNT_W-1:0]  count;
        logic [NUM_DIG_MAX-1:0][STAMP_W-1:0]  stamp;
    } trig_item_t;

    typedef struct packed {
        logic [NUM_DIG_MAX-1:0][TICKS_W-1:0]  spill_ticks;
        logic [ALIGN_W-1:0]                   align0;
        logic [ALIGN_W-1:0]                   align2;
        logic [ALIGN_W-1:0]                   align3;
        logic [NUM_DIG_MAX-1:0]               failed;
    } result_item_t;

    class unwrap_align_board;
        logic [PERIOD_W-1:0] period_reg [NUM_DIG_MAX];
        logic [63:0]         unwrap_base [NUM_DIG_MAX];
        logic [63:0]         prev_full [NUM_DIG_MAX];
        logic [STAMP_W-1:0]  prev_stamp [NUM_DIG_MAX];
        logic [63:0]         spill_origin [NUM_DIG_MAX];
        logic [SPILL_W-1:0]  prev_spill;
        result_item_t        pending_alignments [$];
        int                  errors;

        function new();
            for (int d = 0; d < NUM_DIG_MAX; d++)
            begin
                period_reg[d]   = PERIOD_RESET;
                unwrap_base[d]  = '0;
                prev_full[d]    = '0;
                prev_stamp[d]   = '0;
                spill_origin[d] = '0;
            end
            prev_spill = '0;
            errors     = 0;
        endfunction

        function void set_period(logic [CFG_INDEX_W-1:0] index, logic [PERIOD_W-1:0] value);
            if (index < NUM_CFG_REGS)
                period_reg[index] = value;
        endfunction

        function int pending();
            return pending_alignments.size();
        endfunction

        // Tick and seconds differences disagree by more than 2 s.
        function bit clock_disagrees(longint dts, logic [63:0] dtt);
            longint gap;
            if (dtt >= HUGE_LOW && dtt <= HUGE_HIGH)
                return 1'b1;
            gap = dts * TICKS_PER_SEC - $signed(dtt);
            return (gap > TOL_POS) || (gap < TOL_NEG);
        endfunction

        // floor(ticks * period / 2^16), split so that nothing overflows.
        function logic [63:0] spill_time(logic [TICKS_W-1:0] ticks, logic [PERIOD_W-1:0] period);
            logic [63:0] hi_part;
            logic [63:0] lo_part;
            hi_part = 64'(ticks[47:24]) * 64'(period);
            lo_part = 64'(ticks[23:0]) * 64'(period);
            return (hi_part << 8) + (lo_part >> 16);
        endfunction

        function logic [ALIGN_W-1:0] offset_to_ref(logic [63:0] a, logic [63:0] b);
            logic [63:0] mag;
            logic [63:0] neg;
            if (a >= b)
            begin
                mag = a - b;
                return (mag > ALIGN_MAX) ? ALIGN_MAX[ALIGN_W-1:0] : mag[ALIGN_W-1:0];
            end
            mag = b - a;
            neg = 64'd0 - mag;
            return (mag > ALIGN_MAX + 64'd1) ? ALIGN_MIN : neg[ALIGN_W-1:0];
        endfunction

        function void note_trigger(trig_item_t it);
            bit           first;
            bit           new_spill;
            logic [63:0]  ticks [NUM_DIG_MAX];
            logic [63:0]  tm [NUM_DIG_MAX];
            logic [63:0]  cnt;
            logic [63:0]  full;
            logic [63:0]  diff;
            longint       dts;
            int           steps;
            result_item_t want;

            first     = it.first_event;
            new_spill = !first && (it.spill_id != prev_spill);
            want      = '0;
            for (int d = 0; d < NUM_DIG_MAX; d++)
            begin
                ticks[d] = '0;
                tm[d]    = '0;
            end

            for (int d = 0; d < NUM_DIG; d++)
            begin
                cnt = 64'(it.count[d]);
                if (first)
                begin
                    unwrap_base[d]  = '0;
                    prev_full[d]    = cnt;
                    spill_origin[d] = cnt;
                    prev_stamp[d]   = it.stamp[d];
                end
                dts = $signed({32'd0, it.stamp[d]}) - $signed({32'd0, prev_stamp[d]});
                steps = 0;
                while (clock_disagrees(dts, cnt + unwrap_base[d] - prev_full[d]))
                begin
                    if (steps >= MAX_STEPS)
                    begin
                        want.failed[d] = 1'b1;
                        break;
                    end
                    unwrap_base[d] += WRAP_STEP;
                    steps++;
                end
                full = cnt + unwrap_base[d];
                if (new_spill)
                    spill_origin[d] = full;
                diff = full - spill_origin[d];
                // Ticks before the spill start read as zero; long spills saturate.
                if (diff[63])
                    ticks[d] = '0;
                else if (diff > TICKS_MAX)
                    ticks[d] = TICKS_MAX;
                else
                    ticks[d] = diff;
                tm[d] = spill_time(ticks[d][TICKS_W-1:0], period_reg[d]);
                prev_stamp[d] = it.stamp[d];
                prev_full[d]  = full;
            end
            prev_spill = it.spill_id;

            for (int d = 0; d < NUM_DIG_MAX; d++)
                want.spill_ticks[d] = ticks[d][TICKS_W-1:0];
            want.align0 = offset_to_ref(tm[0], tm[1]);
            want.align2 = (NUM_DIG > 2) ? offset_to_ref(tm[2], tm[1]) : '0;
            want.align3 = (NUM_DIG > 3) ? offset_to_ref(tm[3], tm[1]) : '0;
            pending_alignments.insert(pending_alignments.size(), want);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] seen);
            if (want !== seen)
            begin
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, seen);
                errors++;
            end
        endfunction

        function void check_result(result_item_t seen);
            result_item_t want;
            if (pending_alignments.size() == 0)
            begin
                $display("%0t: result item arrived with none expected, got %h", $time, seen);
                errors++;
                return;
            end
            want = pending_alignments.pop_front();
            for (int d = 0; d < NUM_DIG_MAX; d++)
                compare_field($sformatf("spill_ticks_dig%0d", d),
                              64'(want.spill_ticks[d]), 64'(seen.spill_ticks[d]));
            compare_field("align_dig0", 64'(want.align0), 64'(seen.align0));
            compare_field("align_dig2", 64'(want.align2), 64'(seen.align2));
            compare_field("align_dig3", 64'(want.align3), 64'(seen.align3));
            compare_field("unwrap_failed", 64'(want.failed), 64'(seen.failed));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    ttua_trig_if   trig ();
    ttua_result_if result ();
    ttua_cfg_if    cfg ();

    trigger_time_unwrap_align #(
        .NUM_DIGITIZERS (NUM_DIG),
        .MAX_WRAP_STEPS (MAX_STEPS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .trig   (trig),
        .result (result),
        .cfg    (cfg)
    );

    always #5 clk = ~clk;

    unwrap_align_board board;

    int  trig_gap;
    bit  quiet;
    bit  backlog_req;
    bit  hold_sink;
    bit  need_restart;

    // State of the simulated run of events that the well-formed items follow.
    logic [63:0]        run_tick_origin [NUM_DIG_MAX];
    logic [63:0]        run_truth [NUM_DIG_MAX];
    logic [STAMP_W-1:0] run_stamp_origin [NUM_DIG_MAX];
    longint             run_elapsed;
    logic [SPILL_W-1:0] run_spill;

    initial
    begin
        rst_n              <= 1'b0;
        trig.valid         <= 1'b0;
        trig.first_event   <= 1'b0;
        trig.spill_id      <= '0;
        trig.count_dig0    <= '0;
        trig.count_dig1    <= '0;
        trig.count_dig2    <= '0;
        trig.count_dig3    <= '0;
        trig.stamp_dig0    <= '0;
        trig.stamp_dig1    <= '0;
        trig.stamp_dig2    <= '0;
        trig.stamp_dig3    <= '0;
        result.ready       <= 1'b0;
        cfg.valid          <= 1'b0;
        cfg.index          <= '0;
        cfg.data           <= '0;
        quiet              <= 1'b0;
        backlog_req        <= 1'b0;
        hold_sink          <= 1'b0;
    end

    task automatic send_item(input trig_item_t it, input bit quiet_now, input bit pause_after);
        repeat (trig_gap) @(posedge clk);
        trig.valid       <= 1'b1;
        trig.first_event <= it.first_event;
        trig.spill_id    <= it.spill_id;
        trig.count_dig0  <= it.count[0];
        trig.count_dig1  <= it.count[1];
        trig.count_dig2  <= it.count[2];
        trig.count_dig3  <= it.count[3];
        trig.stamp_dig0  <= it.stamp[0];
        trig.stamp_dig1  <= it.stamp[1];
        trig.stamp_dig2  <= it.stamp[2];
        trig.stamp_dig3  <= it.stamp[3];
        @(posedge clk);
        while (!trig.ready) @(posedge clk);
        board.note_trigger(it);
        // Valid stays up only when the next item follows without a gap.
        trig_gap = quiet_now ? 0 : $urandom_range(0, 14);
        if (trig_gap > 0 || pause_after)
            trig.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (board.pending() != 0) @(posedge clk);
    endtask

    task automatic write_period(input logic [CFG_INDEX_W-1:0] index,
                                input logic [PERIOD_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= index;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        board.set_period(index, value);
    endtask

    task automatic load_periods(input int ph);
        logic [PERIOD_W-1:0] p [NUM_DIG_MAX];
        for (int d = 0; d < NUM_DIG_MAX; d++)
        begin
            case (ph)
                1:       p[d] = '1;
                2:       p[d] = '0;
                3:       p[d] = PERIOD_RESET + 32'($urandom_range(0, 2000)) - 32'd1000;
                5:       p[d] = (d == 1) ? '1 : '0;
                6:       p[d] = (d == 1) ? '0 : '1;
                default: p[d] = $urandom;
            endcase
        end
        wait_drained();
        write_period(REG_PERIOD_DIG0, p[0]);
        write_period(REG_PERIOD_DIG1, p[1]);
        write_period(REG_PERIOD_DIG2, p[2]);
        write_period(REG_PERIOD_DIG3, p[3]);
        // An index past the period registers must leave them all alone.
        if (ph == 1)
            write_period(8'($urandom_range(REG_FIRST_SPARE, 255)), $urandom);
        cfg.valid <= 1'b0;
    endtask

    function automatic trig_item_t uniform_item(bit first, logic [SPILL_W-1:0] spill,
                                                logic [COUNT_W-1:0] cnt,
                                                logic [STAMP_W-1:0] st);
        trig_item_t it;
        it.first_event = first;
        it.spill_id    = spill;
        for (int d = 0; d < NUM_DIG_MAX; d++)
        begin
            it.count[d] = cnt;
            it.stamp[d] = st;
        end
        return it;
    endfunction

    task automatic new_run(output trig_item_t it);
        run_elapsed = 0;
        run_spill   = SPILL_W'($urandom);
        for (int d = 0; d < NUM_DIG_MAX; d++)
        begin
            run_tick_origin[d]  = {24'd0, 8'($urandom_range(0, 255)), 32'($urandom)};
            run_truth[d]        = run_tick_origin[d];
            run_stamp_origin[d] = $urandom_range(0, 32'hFFF0_0000);
            it.count[d]         = run_truth[d][COUNT_W-1:0];
            it.stamp[d]         = run_stamp_origin[d];
        end
        it.first_event = 1'b1;
        it.spill_id    = run_spill;
    endtask

    function automatic longint draw_step();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60)
            return $urandom_range(0, 3);
        else if (sel < 85)
            return $urandom_range(4, 40);
        return $urandom_range(41, 270);
    endfunction

    // Next event of the run: every tick count stays within 2 s of its seconds
    // stamp and never goes backward, so the search always settles in time.
    task automatic next_in_run(output trig_item_t it, input longint dt);
        logic [63:0] base;
        logic [63:0] candidate;
        run_elapsed += dt;
        if ($urandom_range(0, 11) == 0)
            run_spill = ($urandom_range(0, 3) == 0) ? SPILL_W'($urandom) : run_spill + 1'b1;
        it.first_event = 1'b0;
        it.spill_id    = run_spill;
        for (int d = 0; d < NUM_DIG_MAX; d++)
        begin
            base      = run_tick_origin[d] + 64'(run_elapsed * TICK_RATE);
            candidate = base + 64'($urandom_range(0, 200_000_000));
            if (candidate > run_truth[d])
                run_truth[d] = candidate;
            it.count[d] = run_truth[d][COUNT_W-1:0];
            it.stamp[d] = run_stamp_origin[d] + STAMP_W'(run_elapsed);
        end
    endtask

    task automatic broken_item(output trig_item_t it);
        int d;
        d = $urandom_range(0, NUM_DIG_MAX - 1);
        case ($urandom_range(0, 2))
            0:
            begin
                next_in_run(it, draw_step());
                it.stamp[d] = it.stamp[d] - 32'($urandom_range(3, 1000));
            end
            1:
            begin
                next_in_run(it, draw_step());
                it.count[d] = COUNT_W'($urandom);
            end
            default:
                next_in_run(it, $urandom_range(276, 5000));
        endcase
    endtask

    task automatic run_directed();
        trig_item_t it;
        // Straight out of reset, no first event: the search runs into its limit.
        send_item(uniform_item(1'b0, 16'h0000, 31'h7FFF_FFFF, 32'h0000_0000), 1'b0, 1'b0);
        send_item(uniform_item(1'b0, 16'h0000, 31'h0000_0000, 32'h0000_0000), 1'b0, 1'b0);
        // Run start at the top of every field, then a count wrap by one tick.
        send_item(uniform_item(1'b1, 16'hFFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF), 1'b0, 1'b0);
        send_item(uniform_item(1'b0, 16'hFFFF, 31'h0000_0000, 32'hFFFF_FFFF), 1'b0, 1'b0);
        send_item(uniform_item(1'b0, 16'h0000, 31'd100, 32'hFFFF_FFFF), 1'b0, 1'b0);
        // Count below the spill start, then a stamp that steps backward.
        send_item(uniform_item(1'b1, 16'd7, 31'd1000, 32'd5), 1'b0, 1'b0);
        send_item(uniform_item(1'b0, 16'd7, 31'd500, 32'd5), 1'b0, 1'b0);
        send_item(uniform_item(1'b0, 16'd7, 31'd600, 32'd1), 1'b0, 1'b0);
        // Stamps jumping across their whole range in both directions.
        send_item(uniform_item(1'b1, 16'd8, 31'd0, 32'hFFFF_FFFF), 1'b0, 1'b0);
        send_item(uniform_item(1'b0, 16'd8, 31'd0, 32'h0000_0000), 1'b0, 1'b0);
        send_item(uniform_item(1'b1, 16'd9, 31'd0, 32'h0000_0000), 1'b0, 1'b0);
        send_item(uniform_item(1'b0, 16'd9, 31'h7FFF_FFFF, 32'hFFFF_FFFF), 1'b0, 1'b0);
        // Long but legal gaps need many wrap steps; 300 s is beyond the limit.
        send_item(uniform_item(1'b1, 16'd10, 31'd12345, 32'd1000), 1'b0, 1'b0);
        send_item(uniform_item(1'b0, 16'd10, 31'(64'd12345 + 64'(200 * TICK_RATE)),
                               32'd1200), 1'b0, 1'b0);
        send_item(uniform_item(1'b0, 16'd10, 31'(64'd12345 + 64'(300 * TICK_RATE)),
                               32'd1300), 1'b0, 1'b0);
        send_item(uniform_item(1'b0, 16'd10, 31'(64'd12345 + 64'(600 * TICK_RATE)),
                               32'd1600), 1'b0, 1'b0);
        send_item(uniform_item(1'b0, 16'd11, 31'd77, 32'd1601), 1'b0, 1'b0);
        // Digitizers that differ, so the alignment outputs move off zero.
        new_run(it);
        send_item(it, 1'b0, 1'b0);
        next_in_run(it, 64'd30);
        send_item(it, 1'b0, 1'b0);
        next_in_run(it, 64'd2);
        send_item(it, 1'b0, 1'b0);
    endtask

    task automatic run_random(input int n, input int ph);
        trig_item_t it;
        int         sel;
        bit         q;
        for (int i = 0; i < n; i++)
        begin
            q = (i >= 40 && i < 70);
            quiet <= q;
            if (ph == BACKLOG_PHASE && i == 100)
                backlog_req <= 1'b1;
            if (ph == DRAIN_PHASE && i == DRAIN_ITEM)
                wait_drained();
            sel = $urandom_range(0, 99);
            if (need_restart || sel < 5)
            begin
                new_run(it);
                need_restart = 1'b0;
            end
            else if (sel < 87)
                next_in_run(it, draw_step());
            else if (sel < 94)
            begin
                broken_item(it);
                need_restart = 1'b1;
            end
            else
            begin
                it.first_event = 1'($urandom_range(0, 1));
                it.spill_id    = SPILL_W'($urandom);
                for (int d = 0; d < NUM_DIG_MAX; d++)
                begin
                    it.count[d] = COUNT_W'($urandom);
                    it.stamp[d] = $urandom;
                end
                need_restart = 1'b1;
            end
            send_item(it, q, (i == n - 1) || (ph == DRAIN_PHASE && i == DRAIN_ITEM - 1));
        end
        quiet <= 1'b0;
    endtask

    // Result side: random stalls, plus one long hold-off set by its own timer.
    initial
    begin : result_sink
        int           stall;
        result_item_t seen;
        while (rst_n !== 1'b1) @(posedge clk);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 14);
            if (stall > 0 || hold_sink)
            begin
                result.ready <= 1'b0;
                repeat (stall) @(posedge clk);
                while (hold_sink) @(posedge clk);
            end
            result.ready <= 1'b1;
            @(posedge clk);
            while (!result.valid) @(posedge clk);
            seen.spill_ticks[0] = result.spill_ticks_dig0;
            seen.spill_ticks[1] = result.spill_ticks_dig1;
            seen.spill_ticks[2] = result.spill_ticks_dig2;
            seen.spill_ticks[3] = result.spill_ticks_dig3;
            seen.align0         = result.align_dig0;
            seen.align2         = result.align_dig2;
            seen.align3         = result.align_dig3;
            seen.failed         = result.unwrap_failed;
            board.check_result(seen);
        end
    end

    initial
    begin : sink_hold_timer
        while (!backlog_req) @(posedge clk);
        hold_sink <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_sink <= 1'b0;
    end

    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("** trigger_time_unwrap_align: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        board        = new();
        trig_gap     = 0;
        need_restart = 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph == 0)
                run_directed();
            else
                load_periods(ph);
            run_random(PHASE_ITEMS, ph);
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("** trigger_time_unwrap_align: PASSED **");
        else
            $display("** trigger_time_unwrap_align: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ttua_pkg.sv
rtl/ttua_intf.sv
rtl/ttua_period_regs.sv
rtl/ttua_ctrl.sv
rtl/ttua_datapath.sv
rtl/trigger_time_unwrap_align.sv
tb/trigger_time_unwrap_align_test.sv
